// ===== rtl/core/lcc_pkg.sv =====
// Package for the Luhn card number classifier.
// Holds payload widths, result classes, length and prefix constants, and
// the control and result structs shared by the core modules.
package lcc_pkg;

   localparam int CARD_W        = 64;
   localparam int DIGIT_W       = 4;
   localparam int CLASS_W       = 2;
   localparam int COUNT_W       = 5;
   localparam int RADIX         = 10;

   localparam int LEN_SHORT     = 13;
   localparam int LEN_FIFTEEN   = 15;
   localparam int LEN_SIXTEEN   = 16;

   localparam logic [3:0] LEAD_THREE  = 4'd3;
   localparam logic [3:0] LEAD_FOUR   = 4'd4;
   localparam logic [3:0] LEAD_FIVE   = 4'd5;
   localparam logic [3:0] SECOND_FOUR = 4'd4;
   localparam logic [3:0] SECOND_SEVEN = 4'd7;
   localparam logic [3:0] SECOND_LOW  = 4'd1;
   localparam logic [3:0] SECOND_HIGH = 4'd5;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_INVALID   = 2'd0,
      CLASS_PREFIX_3X = 2'd1,
      CLASS_PREFIX_4  = 2'd2,
      CLASS_PREFIX_5X = 2'd3
   } lcc_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_FINISH
   } lcc_state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic drain;
   } lcc_cell_ctrl_type;

   typedef struct packed {
      logic start;
      logic step;
   } lcc_acc_ctrl_type;

   typedef struct packed {
      lcc_class_type        card_class;
      logic                 luhn_ok;
      logic [COUNT_W-1:0]   digit_count;
   } lcc_result_type;

endpackage

// ===== rtl/core/lcc_req_if.sv =====
// Input channel of the Luhn card number classifier: valid, ready and one
// card number. Depends on lcc_pkg for the payload width.
interface lcc_req_if;
   logic                          valid;
   logic                          ready;
   logic [lcc_pkg::CARD_W-1:0]    card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

// ===== rtl/core/lcc_rsp_if.sv =====
// Result channel of the Luhn card number classifier: valid, ready and the
// class, Luhn flag and digit count. Depends on lcc_pkg for the field types.
interface lcc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lcc_pkg::CLASS_W-1:0]   card_class;
   logic                          luhn_ok;
   logic [lcc_pkg::COUNT_W-1:0]   digit_count;

   modport source (output valid, output card_class, output luhn_ok, output digit_count,
                   input ready);
   modport sink   (input valid, input card_class, input luhn_ok, input digit_count,
                   output ready);
endinterface

// ===== rtl/core/lcc_digit_cell.sv =====
// One decimal digit cell of the binary to BCD chain (shift and add three).
// Depends on lcc_pkg for the digit width and the cell control struct.
module lcc_digit_cell (
   input  logic                          clock,
   input  lcc_pkg::lcc_cell_ctrl_type    ctrl,
   input  logic                          carry_in,
   input  logic [lcc_pkg::DIGIT_W-1:0]   digit_in,
   output logic                          carry_out,
   output logic [lcc_pkg::DIGIT_W-1:0]   digit
);

   logic [lcc_pkg::DIGIT_W-1:0] digit_ff;
   logic [lcc_pkg::DIGIT_W-1:0] digit_in_next;
   logic [lcc_pkg::DIGIT_W-1:0] adj;

   always_comb begin
      adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   end

   assign carry_out = adj[lcc_pkg::DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adj[lcc_pkg::DIGIT_W-2:0], carry_in};
      end else if (ctrl.drain) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

// ===== rtl/core/lcc_luhn_acc.sv =====
// Luhn accumulator: takes one decimal digit per cycle, least significant
// first, and keeps the running sum mod ten, the digit count and the two
// leading digits, then classifies. Depends on lcc_pkg.
module lcc_luhn_acc #(
   parameter int MAX_DIGITS = 19
) (
   input  logic                          clock,
   input  lcc_pkg::lcc_acc_ctrl_type     ctrl,
   input  logic [lcc_pkg::DIGIT_W-1:0]   digit,
   input  logic                          overflow,
   output lcc_pkg::lcc_result_type       result
);

   localparam int POS_W = $clog2(MAX_DIGITS + 1);

   logic [POS_W-1:0]            pos_ff, pos_in;
   logic [POS_W-1:0]            count_ff, count_in;
   logic                        odd_ff, odd_in;
   logic [lcc_pkg::DIGIT_W-1:0] sum_ff, sum_in;
   logic [lcc_pkg::DIGIT_W-1:0] lead_ff, lead_in;
   logic [lcc_pkg::DIGIT_W-1:0] second_ff, second_in;
   logic [lcc_pkg::DIGIT_W-1:0] prev_ff, prev_in;
   logic [lcc_pkg::DIGIT_W:0]   dbl;
   logic [lcc_pkg::DIGIT_W:0]   dbl_fold;
   logic [lcc_pkg::DIGIT_W-1:0] term;
   logic [lcc_pkg::DIGIT_W:0]   sum_raw;
   logic                        is_3x, is_4, is_5x;

   always_comb begin
      dbl      = {digit, 1'b0};
      dbl_fold = (dbl >= 5'(lcc_pkg::RADIX)) ? dbl - 5'd9 : dbl;
      term     = odd_ff ? digit : dbl_fold[lcc_pkg::DIGIT_W-1:0];
      sum_raw  = {1'b0, sum_ff} + {1'b0, term};

      pos_in    = pos_ff;
      count_in  = count_ff;
      odd_in    = odd_ff;
      sum_in    = sum_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      prev_in   = prev_ff;

      priority if (ctrl.start) begin
         pos_in    = '0;
         count_in  = '0;
         odd_in    = 1'b1;
         sum_in    = '0;
         lead_in   = '0;
         second_in = '0;
         prev_in   = '0;
      end else if (ctrl.step) begin
         pos_in  = pos_ff + POS_W'(1);
         odd_in  = ~odd_ff;
         sum_in  = (sum_raw >= 5'(lcc_pkg::RADIX)) ?
                   4'(sum_raw - 5'(lcc_pkg::RADIX)) : sum_raw[lcc_pkg::DIGIT_W-1:0];
         prev_in = digit;
         if (digit != '0) begin
            count_in  = pos_ff + POS_W'(1);
            lead_in   = digit;
            second_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      count_ff  <= count_in;
      odd_ff    <= odd_in;
      sum_ff    <= sum_in;
      lead_ff   <= lead_in;
      second_ff <= second_in;
      prev_ff   <= prev_in;
   end

   always_comb begin
      is_3x = (count_ff == POS_W'(lcc_pkg::LEN_FIFTEEN)) && (lead_ff == lcc_pkg::LEAD_THREE)
              && ((second_ff == lcc_pkg::SECOND_FOUR) || (second_ff == lcc_pkg::SECOND_SEVEN));
      is_4  = ((count_ff == POS_W'(lcc_pkg::LEN_SHORT)) ||
               (count_ff == POS_W'(lcc_pkg::LEN_SIXTEEN))) && (lead_ff == lcc_pkg::LEAD_FOUR);
      is_5x = (count_ff == POS_W'(lcc_pkg::LEN_SIXTEEN)) && (lead_ff == lcc_pkg::LEAD_FIVE)
              && (second_ff >= lcc_pkg::SECOND_LOW) && (second_ff <= lcc_pkg::SECOND_HIGH);

      result.card_class  = lcc_pkg::CLASS_INVALID;
      result.luhn_ok     = 1'b0;
      result.digit_count = lcc_pkg::COUNT_W'(MAX_DIGITS + 1);
      if (!overflow) begin
         result.luhn_ok     = (sum_ff == '0);
         result.digit_count = lcc_pkg::COUNT_W'(count_ff);
         if (result.luhn_ok && (count_ff != '0)) begin
            priority if (is_3x) begin
               result.card_class = lcc_pkg::CLASS_PREFIX_3X;
            end else if (is_4) begin
               result.card_class = lcc_pkg::CLASS_PREFIX_4;
            end else if (is_5x) begin
               result.card_class = lcc_pkg::CLASS_PREFIX_5X;
            end else begin
               result.card_class = lcc_pkg::CLASS_INVALID;
            end
         end
      end
   end

endmodule

// ===== rtl/core/luhn_card_number_classifier_top.sv =====
// Top level of the Luhn card number classifier.
// Depends on lcc_pkg, lcc_req_if, lcc_rsp_if, lcc_digit_cell and lcc_luhn_acc.
//
// Usage:
//   The req channel carries one card number per item as a 64-bit unsigned
//   integer. The rsp channel returns one item per card number with the class,
//   the Luhn pass flag and the decimal digit count.
//   The number is shifted, one bit per cycle, into a row of MAX_DIGITS BCD
//   digit cells. The digit row is then drained into the Luhn accumulator,
//   one digit per cycle. The output register is then loaded once it is
//   empty or rsp takes its item, and the block returns to idle. A new
//   item is accepted only in idle, after the previous result is loaded.
//   A carry out of the top digit cell marks a number with more than
//   MAX_DIGITS digits, which is reported invalid with a saturated count.
//   The output register holds a result while rsp stalls, and a new item is
//   accepted meanwhile; its result waits for the register to empty.
//   A synchronous reset returns the block to idle and drops rsp valid.
module luhn_card_number_classifier_top #(
   parameter int MAX_DIGITS = 19
) (
   input  logic        clock,
   input  logic        reset,
   lcc_req_if.sink     req_chan,
   lcc_rsp_if.source   rsp_chan
);

   localparam int STEP_W = $clog2(lcc_pkg::CARD_W);

   lcc_pkg::lcc_state_type       state_ff, state_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [lcc_pkg::CARD_W-1:0]   bin_ff, bin_in;
   logic                         ovf_ff, ovf_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lcc_pkg::lcc_result_type      rsp_data_ff, rsp_data_in;

   lcc_pkg::lcc_cell_ctrl_type   cell_ctrl;
   lcc_pkg::lcc_acc_ctrl_type    acc_ctrl;
   lcc_pkg::lcc_result_type      acc_result;
   logic                         load_rsp;

   logic [lcc_pkg::DIGIT_W-1:0]  cell_digit [MAX_DIGITS];
   logic                         cell_carry [MAX_DIGITS];

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      logic                         cin;
      logic [lcc_pkg::DIGIT_W-1:0]  din;

      if (i == 0) begin : g_low
         assign cin = bin_ff[lcc_pkg::CARD_W-1];
      end else begin : g_mid
         assign cin = cell_carry[i-1];
      end

      if (i == MAX_DIGITS - 1) begin : g_high
         assign din = '0;
      end else begin : g_inner
         assign din = cell_digit[i+1];
      end

      lcc_digit_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .carry_in  (cin),
         .digit_in  (din),
         .carry_out (cell_carry[i]),
         .digit     (cell_digit[i])
      );
   end

   lcc_luhn_acc #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_acc (
      .clock    (clock),
      .ctrl     (acc_ctrl),
      .digit    (cell_digit[0]),
      .overflow (ovf_ff),
      .result   (acc_result)
   );

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      bin_in          = bin_ff;
      ovf_in          = ovf_ff;
      cell_ctrl       = '0;
      acc_ctrl        = '0;
      load_rsp        = 1'b0;
      req_chan.ready  = 1'b0;

      unique case (state_ff)
         lcc_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               bin_in          = req_chan.card_number;
               ovf_in          = 1'b0;
               step_in         = '0;
               cell_ctrl.clear = 1'b1;
               acc_ctrl.start  = 1'b1;
               state_in        = lcc_pkg::ST_CONVERT;
            end
         end
         lcc_pkg::ST_CONVERT: begin
            cell_ctrl.dabble = 1'b1;
            bin_in           = {bin_ff[lcc_pkg::CARD_W-2:0], 1'b0};
            ovf_in           = ovf_ff | cell_carry[MAX_DIGITS-1];
            step_in          = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lcc_pkg::CARD_W - 1)) begin
               step_in  = '0;
               state_in = lcc_pkg::ST_SCAN;
            end
         end
         lcc_pkg::ST_SCAN: begin
            cell_ctrl.drain = 1'b1;
            acc_ctrl.step   = 1'b1;
            step_in         = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MAX_DIGITS - 1)) begin
               step_in  = '0;
               state_in = lcc_pkg::ST_FINISH;
            end
         end
         lcc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = lcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = load_rsp ? acc_result : rsp_data_ff;
      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcc_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.card_class  = rsp_data_ff.card_class;
   assign rsp_chan.luhn_ok     = rsp_data_ff.luhn_ok;
   assign rsp_chan.digit_count = rsp_data_ff.digit_count;

endmodule
